>>> hw/rtl/smbrr_pkg.sv
// ----------------------------------------------------------------------------
// SMBus register read master - shared package
// Transaction payload types, configuration register map and status codes.
// ----------------------------------------------------------------------------
package smbrr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_SETTLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_GAP       = 3'd4;

  // reset values of the configuration registers
  localparam logic [15:0] RST_PHASE_TICKS = 16'd20;
  localparam logic [15:0] RST_ACK_SETTLE  = 16'd200;
  localparam logic [15:0] RST_ACK_TIMEOUT = 16'd2000;
  localparam logic [15:0] RST_BYTE_GAP    = 16'd60;
  localparam logic [15:0] RST_STOP_GAP    = 16'd50;

  // completion status codes
  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_OK      = 2'd1;
  localparam logic [1:0] STATUS_ACK_ERR = 2'd2;

  // read direction bit of the device address
  localparam logic [7:0] ADDR_READ_BIT = 8'h01;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic [15:0] ack_settle_ticks;
    logic [15:0] ack_timeout_polls;
    logic [15:0] byte_gap_ticks;
    logic [15:0] stop_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] byte_count;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       busy_res;
    logic [1:0] status;
  } out_item_t;

endpackage

>>> hw/rtl/smbrr_cfg.sv
// ----------------------------------------------------------------------------
// SMBus register read master - configuration registers
// Holds the bus timing registers, written through a valid/ready port.
// ----------------------------------------------------------------------------
module smbrr_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [smbrr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [smbrr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output smbrr_pkg::cfg_t                   cfg_o
);
  import smbrr_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PHASE_TICKS: cfg_d.phase_ticks       = cfg_data_i;
        CFG_ACK_SETTLE:  cfg_d.ack_settle_ticks  = cfg_data_i;
        CFG_ACK_TIMEOUT: cfg_d.ack_timeout_polls = cfg_data_i;
        CFG_BYTE_GAP:    cfg_d.byte_gap_ticks    = cfg_data_i;
        CFG_STOP_GAP:    cfg_d.stop_gap_ticks    = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks       <= RST_PHASE_TICKS;
      cfg_q.ack_settle_ticks  <= RST_ACK_SETTLE;
      cfg_q.ack_timeout_polls <= RST_ACK_TIMEOUT;
      cfg_q.byte_gap_ticks    <= RST_BYTE_GAP;
      cfg_q.stop_gap_ticks    <= RST_STOP_GAP;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/smbrr_seq.sv
// ----------------------------------------------------------------------------
// SMBus register read master - bus sequencer
// Holds the transaction state and works out one tick per step: line levels,
// received byte and completion status.
// ----------------------------------------------------------------------------
module smbrr_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  smbrr_pkg::in_item_t   item_i,
  input  smbrr_pkg::cfg_t       cfg_i,
  output smbrr_pkg::out_item_t  res_o
);
  import smbrr_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_START1    = 4'd1;
  localparam logic [3:0] S_SEND_DEV  = 4'd2;
  localparam logic [3:0] S_ACK_DEV   = 4'd3;
  localparam logic [3:0] S_SEND_REG  = 4'd4;
  localparam logic [3:0] S_ACK_REG   = 4'd5;
  localparam logic [3:0] S_START2    = 4'd6;
  localparam logic [3:0] S_SEND_DEVR = 4'd7;
  localparam logic [3:0] S_ACK_DEVR  = 4'd8;
  localparam logic [3:0] S_GAP       = 4'd9;
  localparam logic [3:0] S_READ      = 4'd10;
  localparam logic [3:0] S_ACKOUT    = 4'd11;
  localparam logic [3:0] S_STOPGAP   = 4'd12;
  localparam logic [3:0] S_STOP      = 4'd13;

  logic [3:0]  state_q, state_d;
  logic [2:0]  micro_q, micro_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] poll_q, poll_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  bytes_q, bytes_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  count_q, count_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;

  logic [3:0]  stp;
  logic [2:0]  mic;
  logic [15:0] plen;
  logic [15:0] poll_base;
  logic [16:0] poll_next;
  logic [7:0]  done_cnt;
  logic        last;
  logic        fire;

  assign plen = (cfg_i.phase_ticks == 16'd0) ? 16'd1 : cfg_i.phase_ticks;

  always_comb begin
    state_d = state_q;
    micro_d = micro_q;
    cnt_d   = cnt_q;
    poll_d  = poll_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    bytes_d = bytes_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    count_d = count_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    res_o   = '0;
    fire    = 1'b0;
    stp     = state_q;
    mic     = micro_q;

    if (item_i.action) begin
      // new transaction: restart from the present line levels
      dev_d   = item_i.device_address;
      reg_d   = item_i.register_address;
      count_d = (item_i.byte_count == 8'd0) ? 8'd1 : item_i.byte_count;
      bytes_d = 8'd0;
      bit_d   = 3'd0;
      shift_d = 8'd0;
      poll_d  = 16'd0;
      cnt_d   = 16'd0;
      stp     = S_START1;
      mic     = 3'd0;
      state_d = S_START1;
      micro_d = 3'd0;
      fire    = 1'b1;
    end else if (state_q != S_IDLE) begin
      cnt_d = (cnt_q != 16'd0) ? cnt_q - 16'd1 : 16'd0;
      fire  = (cnt_q <= 16'd1);
    end

    poll_base = (mic == 3'd0) ? 16'd0 : poll_q;
    poll_next = {1'b0, poll_base} + 17'd1;
    done_cnt  = (mic == 3'd0) ? bytes_q + 8'd1 : bytes_q;
    last      = (done_cnt >= count_q);

    if (fire) begin
      case (stp)
        S_START1, S_START2: begin
          case (mic)
            3'd0:    scl_d = 1'b1;
            3'd1:    sda_d = 1'b1;
            3'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
          cnt_d = plen;
          if (mic >= 3'd3) begin
            state_d = stp + 4'd1;
            micro_d = 3'd0;
          end else begin
            micro_d = mic + 3'd1;
          end
        end
        S_SEND_DEV, S_SEND_REG, S_SEND_DEVR: begin
          cnt_d = plen;
          case (mic)
            3'd0: begin
              if (stp == S_SEND_DEV) begin
                shift_d = dev_q;
              end else if (stp == S_SEND_REG) begin
                shift_d = reg_q;
              end else begin
                shift_d = dev_q | ADDR_READ_BIT;
              end
              bit_d   = 3'd7;
              micro_d = 3'd1;
            end
            3'd1: begin
              sda_d   = shift_q[bit_q];
              micro_d = 3'd2;
            end
            3'd2: begin
              scl_d   = 1'b1;
              micro_d = 3'd3;
            end
            default: begin
              scl_d = 1'b0;
              if (bit_q == 3'd0) begin
                state_d = stp + 4'd1;
                micro_d = 3'd0;
              end else begin
                bit_d   = bit_q - 3'd1;
                micro_d = 3'd1;
              end
            end
          endcase
        end
        S_ACK_DEV, S_ACK_REG, S_ACK_DEVR: begin
          if (mic == 3'd0) begin
            sda_d   = 1'b1;
            poll_d  = 16'd0;
            cnt_d   = cfg_i.ack_settle_ticks;
            micro_d = 3'd1;
          end
          // poll at once when no settle wait is set
          if (mic == 3'd1 || (mic == 3'd0 && cfg_i.ack_settle_ticks == 16'd0)) begin
            if (!item_i.sda_in) begin
              cnt_d   = plen;
              micro_d = 3'd2;
            end else if (poll_next >= {1'b0, cfg_i.ack_timeout_polls}) begin
              res_o.status = STATUS_ACK_ERR;
              state_d      = S_IDLE;
              micro_d      = 3'd0;
            end else begin
              poll_d = poll_next[15:0];
              cnt_d  = 16'd0;
            end
          end else if (mic == 3'd2) begin
            scl_d   = 1'b1;
            cnt_d   = plen;
            micro_d = 3'd3;
          end else if (mic != 3'd0) begin
            scl_d   = 1'b0;
            cnt_d   = plen;
            state_d = stp + 4'd1;
            micro_d = 3'd0;
          end
        end
        S_GAP, S_READ: begin
          if (stp == S_GAP) begin
            cnt_d   = cfg_i.byte_gap_ticks;
            state_d = S_READ;
            micro_d = 3'd0;
          end
          if (stp == S_READ || cfg_i.byte_gap_ticks == 16'd0) begin
            cnt_d = plen;
            if (stp == S_GAP || mic == 3'd0) begin
              sda_d   = 1'b1;
              bit_d   = 3'd7;
              micro_d = 3'd1;
            end else if (mic == 3'd1) begin
              shift_d[bit_q] = item_i.sda_in;
              micro_d        = 3'd2;
            end else if (mic == 3'd2) begin
              scl_d   = 1'b1;
              micro_d = 3'd3;
            end else begin
              scl_d = 1'b0;
              if (bit_q == 3'd0) begin
                state_d = S_ACKOUT;
                micro_d = 3'd0;
              end else begin
                bit_d   = bit_q - 3'd1;
                micro_d = 3'd1;
              end
            end
          end
        end
        S_ACKOUT: begin
          case (mic)
            3'd0: begin
              bytes_d          = done_cnt;
              res_o.byte_valid = 1'b1;
              res_o.read_byte  = shift_q;
              res_o.last_byte  = last;
              scl_d            = 1'b0;
            end
            3'd1:    sda_d = last;
            3'd2:    scl_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
          cnt_d = plen;
          if (mic >= 3'd3) begin
            state_d = last ? S_STOPGAP : S_GAP;
            micro_d = 3'd0;
          end else begin
            micro_d = mic + 3'd1;
          end
        end
        S_STOPGAP: begin
          cnt_d   = cfg_i.stop_gap_ticks;
          state_d = S_STOP;
          micro_d = 3'd0;
          if (cfg_i.stop_gap_ticks == 16'd0) begin
            scl_d   = 1'b0;
            cnt_d   = plen;
            micro_d = 3'd1;
          end
        end
        S_STOP: begin
          if (mic >= 3'd4) begin
            res_o.status = STATUS_OK;
            state_d      = S_IDLE;
            micro_d      = 3'd0;
          end else begin
            case (mic)
              3'd0:    scl_d = 1'b0;
              3'd1:    sda_d = 1'b0;
              3'd2:    scl_d = 1'b1;
              default: sda_d = 1'b1;
            endcase
            cnt_d   = plen;
            micro_d = mic + 3'd1;
          end
        end
        default: begin
          state_d = S_IDLE;
          micro_d = 3'd0;
        end
      endcase
    end

    res_o.scl_level   = scl_d;
    res_o.sda_release = sda_d;
    res_o.busy_res    = (state_d != S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      micro_q <= 3'd0;
      cnt_q   <= 16'd0;
      poll_q  <= 16'd0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      bytes_q <= 8'd0;
      dev_q   <= 8'd0;
      reg_q   <= 8'd0;
      count_q <= 8'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else if (step_i) begin
      state_q <= state_d;
      micro_q <= micro_d;
      cnt_q   <= cnt_d;
      poll_q  <= poll_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      bytes_q <= bytes_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      count_q <= count_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

endmodule

>>> hw/rtl/smbus_register_read_master.sv
// ----------------------------------------------------------------------------
// SMBus register read master - top level
// Input register, bus sequencer and result register.
// ----------------------------------------------------------------------------
// Path: input register, sequencer step, result register.
// Throughput: one transaction per cycle unless the result side stalls, set by
// the single sequencer step between the input and result registers.
// Reset: asynchronous, active low; lines released high, sequencer idle,
// configuration registers back to their default timing.
module smbus_register_read_master (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  smbrr_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output smbrr_pkg::out_item_t              out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [smbrr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [smbrr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import smbrr_pkg::*;

  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  out_item_t res;
  cfg_t      cfg;
  logic      advance;
  logic      accept;

  // move the held transaction on when the result register is free
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  smbrr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  smbrr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

>>> verif/smbrr_bus_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SMBus register read master - bus sequencer checker
// Follows every transaction on the input and configuration channels, works
// out the line levels and read results the master must return, and compares
// each accepted result with the oldest one still owed.
// ----------------------------------------------------------------------------
module smbrr_bus_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  smbrr_pkg::in_item_t             in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  smbrr_pkg::out_item_t            out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [smbrr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smbrr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     outstanding_o,
  output int unsigned                     checked_o,
  output int unsigned                     bytes_o,
  output int unsigned                     done_ok_o,
  output int unsigned                     ack_err_o
);
  import smbrr_pkg::*;

  typedef enum logic [3:0] {
    BUS_IDLE, BUS_START1, BUS_SEND_DEV, BUS_ACK_DEV, BUS_SEND_REG, BUS_ACK_REG,
    BUS_START2, BUS_SEND_DEVR, BUS_ACK_DEVR, BUS_GAP, BUS_READ, BUS_ACK_OUT,
    BUS_STOP_GAP, BUS_STOP
  } bus_step_e;

  cfg_t        timing;
  bus_step_e   step;
  logic [2:0]  micro;
  logic [15:0] wait_cnt;
  logic [15:0] polls;
  logic [2:0]  bit_idx;
  logic [7:0]  shreg;
  logic [7:0]  nread;
  logic [7:0]  dev_q;
  logic [7:0]  reg_q;
  logic [7:0]  cnt_q;
  logic        scl_q;
  logic        sda_q;
  logic        poll_hold;
  out_item_t   tick_res;
  out_item_t   fresh;
  out_item_t   oldest;

  out_item_t   owed_levels_q[$];
  int unsigned fails, owed, checked, bytes_read, done_ok, ack_errs;

  assign fail_count_o  = fails;
  assign outstanding_o = owed;
  assign checked_o     = checked;
  assign bytes_o       = bytes_read;
  assign done_ok_o     = done_ok;
  assign ack_err_o     = ack_errs;

  initial begin
    fails = 0;
    checked = 0;
    bytes_read = 0;
    done_ok = 0;
    ack_errs = 0;
    owed = 0;
  end

  function automatic void clear_bus();
    timing.phase_ticks       = RST_PHASE_TICKS;
    timing.ack_settle_ticks  = RST_ACK_SETTLE;
    timing.ack_timeout_polls = RST_ACK_TIMEOUT;
    timing.byte_gap_ticks    = RST_BYTE_GAP;
    timing.stop_gap_ticks    = RST_STOP_GAP;
    step     = BUS_IDLE;
    micro    = 3'd0;
    wait_cnt = 16'd0;
    polls    = 16'd0;
    bit_idx  = 3'd0;
    shreg    = 8'd0;
    nread    = 8'd0;
    dev_q    = 8'd0;
    reg_q    = 8'd0;
    cnt_q    = 8'd0;
    scl_q    = 1'b1;
    sda_q    = 1'b1;
  endfunction

  function automatic void write_timing(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_PHASE_TICKS: timing.phase_ticks       = val;
      CFG_ACK_SETTLE:  timing.ack_settle_ticks  = val;
      CFG_ACK_TIMEOUT: timing.ack_timeout_polls = val;
      CFG_BYTE_GAP:    timing.byte_gap_ticks    = val;
      CFG_STOP_GAP:    timing.stop_gap_ticks    = val;
      default: ;
    endcase
  endfunction

  // a zero phase length still takes one tick
  function automatic logic [15:0] phase_len();
    return (timing.phase_ticks == 16'd0) ? 16'd1 : timing.phase_ticks;
  endfunction

  function automatic void quarter_step(input bus_step_e next);
    wait_cnt = phase_len();
    if (micro >= 3'd3) begin
      step  = next;
      micro = 3'd0;
    end else begin
      micro = micro + 3'd1;
    end
  endfunction

  function automatic void bus_action(input logic sda_bit);
    case (step)
      BUS_START1, BUS_START2: begin
        case (micro)
          3'd0: scl_q = 1'b1;
          3'd1: sda_q = 1'b1;
          3'd2: sda_q = 1'b0;
          default: scl_q = 1'b0;
        endcase
        quarter_step(bus_step_e'(step + 4'd1));
      end
      BUS_SEND_DEV, BUS_SEND_REG, BUS_SEND_DEVR: begin
        wait_cnt = phase_len();
        case (micro)
          3'd0: begin
            if (step == BUS_SEND_DEV) shreg = dev_q;
            else if (step == BUS_SEND_REG) shreg = reg_q;
            else shreg = dev_q | ADDR_READ_BIT;
            bit_idx = 3'd7;
            micro   = 3'd1;
          end
          3'd1: begin
            sda_q = shreg[bit_idx];
            micro = 3'd2;
          end
          3'd2: begin
            scl_q = 1'b1;
            micro = 3'd3;
          end
          default: begin
            scl_q = 1'b0;
            if (bit_idx == 3'd0) begin
              step  = bus_step_e'(step + 4'd1);
              micro = 3'd0;
            end else begin
              bit_idx = bit_idx - 3'd1;
              micro   = 3'd1;
            end
          end
        endcase
      end
      BUS_ACK_DEV, BUS_ACK_REG, BUS_ACK_DEVR: begin
        case (micro)
          3'd0: begin
            sda_q    = 1'b1;
            polls    = 16'd0;
            wait_cnt = timing.ack_settle_ticks;
            micro    = 3'd1;
          end
          3'd1: begin
            if (!sda_bit) begin
              wait_cnt = phase_len();
              micro    = 3'd2;
            end else begin
              polls = polls + 16'd1;
              if (polls >= timing.ack_timeout_polls) begin
                tick_res.status = STATUS_ACK_ERR;
                step  = BUS_IDLE;
                micro = 3'd0;
              end else begin
                // hold here and poll again next tick
                poll_hold = 1'b1;
              end
            end
          end
          3'd2: begin
            scl_q    = 1'b1;
            wait_cnt = phase_len();
            micro    = 3'd3;
          end
          default: begin
            scl_q    = 1'b0;
            wait_cnt = phase_len();
            step     = bus_step_e'(step + 4'd1);
            micro    = 3'd0;
          end
        endcase
      end
      BUS_GAP: begin
        wait_cnt = timing.byte_gap_ticks;
        step     = BUS_READ;
        micro    = 3'd0;
      end
      BUS_READ: begin
        wait_cnt = phase_len();
        case (micro)
          3'd0: begin
            sda_q   = 1'b1;
            bit_idx = 3'd7;
            micro   = 3'd1;
          end
          3'd1: begin
            // sample before SCL rises
            shreg[bit_idx] = sda_bit;
            micro = 3'd2;
          end
          3'd2: begin
            scl_q = 1'b1;
            micro = 3'd3;
          end
          default: begin
            scl_q = 1'b0;
            if (bit_idx == 3'd0) begin
              step  = BUS_ACK_OUT;
              micro = 3'd0;
            end else begin
              bit_idx = bit_idx - 3'd1;
              micro   = 3'd1;
            end
          end
        endcase
      end
      BUS_ACK_OUT: begin
        case (micro)
          3'd0: begin
            nread = nread + 8'd1;
            tick_res.byte_valid = 1'b1;
            tick_res.read_byte  = shreg;
            tick_res.last_byte  = (nread >= cnt_q);
            scl_q = 1'b0;
          end
          3'd1: sda_q = (nread >= cnt_q);
          3'd2: scl_q = 1'b1;
          default: scl_q = 1'b0;
        endcase
        if (nread >= cnt_q) quarter_step(BUS_STOP_GAP);
        else quarter_step(BUS_GAP);
      end
      BUS_STOP_GAP: begin
        wait_cnt = timing.stop_gap_ticks;
        step     = BUS_STOP;
        micro    = 3'd0;
      end
      BUS_STOP: begin
        if (micro >= 3'd4) begin
          tick_res.status = STATUS_OK;
          step  = BUS_IDLE;
          micro = 3'd0;
        end else begin
          case (micro)
            3'd0: scl_q = 1'b0;
            3'd1: sda_q = 1'b0;
            3'd2: scl_q = 1'b1;
            default: sda_q = 1'b1;
          endcase
          wait_cnt = phase_len();
          micro    = micro + 3'd1;
        end
      end
      default: begin
        step  = BUS_IDLE;
        micro = 3'd0;
      end
    endcase
  endfunction

  function automatic out_item_t step_sequencer(input in_item_t it);
    tick_res  = '0;
    poll_hold = 1'b0;
    if (it.action) begin
      dev_q    = it.device_address;
      reg_q    = it.register_address;
      cnt_q    = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
      nread    = 8'd0;
      bit_idx  = 3'd0;
      shreg    = 8'd0;
      polls    = 16'd0;
      wait_cnt = 16'd0;
      step     = BUS_START1;
      micro    = 3'd0;
    end else if (step != BUS_IDLE && wait_cnt != 16'd0) begin
      wait_cnt = wait_cnt - 16'd1;
    end
    // zero-length waits chain within the same tick
    while (step != BUS_IDLE && wait_cnt == 16'd0 && !poll_hold) bus_action(it.sda_in);
    tick_res.scl_level   = scl_q;
    tick_res.sda_release = sda_q;
    tick_res.busy_res    = (step != BUS_IDLE);
    return tick_res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fails = fails + 1;
    $display("[%0t] result %0d: %s got %0h want %0h", $time, checked, what, got, want);
  endtask

  task automatic compare_levels(input out_item_t got, input out_item_t want);
    if (got.scl_level !== want.scl_level)
      report_mismatch("scl_level", 32'(got.scl_level), 32'(want.scl_level));
    if (got.sda_release !== want.sda_release)
      report_mismatch("sda_release", 32'(got.sda_release), 32'(want.sda_release));
    if (got.read_byte !== want.read_byte)
      report_mismatch("read_byte", 32'(got.read_byte), 32'(want.read_byte));
    if (got.byte_valid !== want.byte_valid)
      report_mismatch("byte_valid", 32'(got.byte_valid), 32'(want.byte_valid));
    if (got.last_byte !== want.last_byte)
      report_mismatch("last_byte", 32'(got.last_byte), 32'(want.last_byte));
    if (got.busy_res !== want.busy_res)
      report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
    if (got.status !== want.status)
      report_mismatch("status", 32'(got.status), 32'(want.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_bus();
      owed_levels_q.delete();
      owed = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) write_timing(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) begin
        fresh = step_sequencer(in_data_i);
        owed_levels_q.push_back(fresh);
        if (fresh.byte_valid) bytes_read = bytes_read + 1;
        if (fresh.status == STATUS_OK) done_ok = done_ok + 1;
        if (fresh.status == STATUS_ACK_ERR) ack_errs = ack_errs + 1;
      end
      if (out_valid_i && !out_stall_i) begin
        if (owed_levels_q.size() == 0) begin
          report_mismatch("result with nothing owed", 32'(out_data_i), 32'd0);
        end else begin
          oldest = owed_levels_q.pop_front();
          compare_levels(out_data_i, oldest);
        end
        checked = checked + 1;
      end
      owed = owed_levels_q.size();
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SMBus register read master - testbench top
// Drives start and tick transactions and register writes into the master,
// stalls the result side at random, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import smbrr_pkg::*;

  localparam int unsigned IDLE_PCT     = 28;
  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_OFF     = 4;
  localparam logic        ACT_TICK     = 1'b0;
  localparam logic        ACT_START    = 1'b1;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  quiet = 1'b0;

  int unsigned fail_count, outstanding, checked, bytes_seen, done_ok, ack_errs;
  int unsigned idle_run = 0;
  int unsigned starts = 0;
  cfg_t        cur_cfg;

  smbus_register_read_master dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  smbrr_bus_check u_bus_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .bytes_o       (bytes_seen),
    .done_ok_o     (done_ok),
    .ack_err_o     (ack_errs)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

  // end the run if nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= STALL_LIMIT) begin
      $display("tb: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // low_pct: chance in a hundred that the device pulls SDA low
  function automatic in_item_t tick_item(input int unsigned low_pct);
    in_item_t it;
    it.action           = ACT_TICK;
    it.device_address   = 8'($urandom);
    it.register_address = 8'($urandom);
    it.byte_count       = 8'($urandom);
    it.sda_in           = ($urandom_range(99) >= low_pct);
    return it;
  endfunction

  function automatic in_item_t start_item(input logic [7:0] dev, input logic [7:0] regaddr,
                                          input logic [7:0] nbytes,
                                          input int unsigned low_pct);
    in_item_t it;
    it = tick_item(low_pct);
    it.action           = ACT_START;
    it.device_address   = dev;
    it.register_address = regaddr;
    it.byte_count       = nbytes;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_item(input in_item_t it);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_ticks(input int unsigned n, input int unsigned low_pct);
    for (int unsigned i = 0; i < n; i++) push_item(tick_item(low_pct));
  endtask

  task automatic start_read(input logic [7:0] dev, input logic [7:0] regaddr,
                            input logic [7:0] nbytes, input int unsigned low_pct);
    starts = starts + 1;
    push_item(start_item(dev, regaddr, nbytes, low_pct));
  endtask

  // hold the sender until every owed result is in, then let the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_cfg(input cfg_t c, input logic spare);
    logic [CFG_IDX_W-1:0] spare_idx;
    drain();
    cfg_write(CFG_PHASE_TICKS, c.phase_ticks);
    cfg_write(CFG_ACK_SETTLE, c.ack_settle_ticks);
    cfg_write(CFG_ACK_TIMEOUT, c.ack_timeout_polls);
    cfg_write(CFG_BYTE_GAP, c.byte_gap_ticks);
    cfg_write(CFG_STOP_GAP, c.stop_gap_ticks);
    if (spare) begin
      // an index past the map must leave the timing alone
      spare_idx = CFG_STOP_GAP + 3'd1 + 3'($urandom_range(2));
      cfg_write(spare_idx, 16'($urandom));
    end
    cfg_valid <= 1'b0;
    cur_cfg = c;
    @(negedge clk);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.phase_ticks       = 16'($urandom_range(2));
    c.ack_settle_ticks  = 16'($urandom_range(4));
    c.ack_timeout_polls = ($urandom_range(3) == 0) ? RST_ACK_TIMEOUT :
                          16'($urandom_range(3));
    c.byte_gap_ticks    = 16'($urandom_range(5));
    c.stop_gap_ticks    = 16'($urandom_range(5));
    return c;
  endfunction

  // rough tick count for a whole read at the current timing
  function automatic int unsigned read_ticks(input cfg_t c, input int unsigned nbytes);
    int unsigned p, n;
    p = (c.phase_ticks == 16'd0) ? 1 : 32'(c.phase_ticks);
    n = (nbytes == 0) ? 1 : nbytes;
    return p * (110 + 30 * n) + 3 * 32'(c.ack_settle_ticks) + n * 32'(c.byte_gap_ticks) +
           32'(c.stop_gap_ticks) + 24;
  endfunction

  initial begin
    cfg_t        c;
    int unsigned sent, roll, low_pct, nbytes, len;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_cfg.phase_ticks       = RST_PHASE_TICKS;
    cur_cfg.ack_settle_ticks  = RST_ACK_SETTLE;
    cur_cfg.ack_timeout_polls = RST_ACK_TIMEOUT;
    cur_cfg.byte_gap_ticks    = RST_BYTE_GAP;
    cur_cfg.stop_gap_ticks    = RST_STOP_GAP;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // tick on an idle master, then field extremes at reset timing
    push_item(tick_item(50));
    start_read(8'hFF, 8'h00, 8'h00, 100);
    run_ticks(3, 100);
    // a start while busy aborts and begins again
    start_read(8'h00, 8'hFF, 8'hFF, 0);
    run_ticks(2, 0);

    c.phase_ticks       = 16'hFFFF;
    c.ack_settle_ticks  = 16'hFFFF;
    c.ack_timeout_polls = 16'hFFFF;
    c.byte_gap_ticks    = 16'hFFFF;
    c.stop_gap_ticks    = 16'hFFFF;
    program_cfg(c, 1'b1);
    start_read(8'hA5, 8'h5A, 8'd1, 50);
    run_ticks(3, 50);

    // zero phase acts as one, zero timeout gives up on the first high poll
    c = '0;
    program_cfg(c, 1'b0);
    start_read(8'h3C, 8'hC3, 8'd2, 0);
    run_ticks(32, 0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      quiet <= (sent >= 450 && sent < 800);
      roll = $urandom_range(99);
      if (roll < 30) program_cfg(random_cfg(), ($urandom_range(3) == 0));
      else if (roll < 40) drain();
      case ($urandom_range(2))
        0: low_pct = 50;
        1: low_pct = 80;
        default: low_pct = 95;
      endcase
      if ($urandom_range(4) == 0) nbytes = $urandom_range(255);
      else nbytes = $urandom_range(3);
      start_read(8'($urandom), 8'($urandom), 8'(nbytes), low_pct);
      if (nbytes > 3 || $urandom_range(4) == 0) begin
        // broken off early by the next start
        len = $urandom_range(1, 200);
      end else begin
        // let it finish; spare ticks land on an idle master
        len = read_ticks(cur_cfg, nbytes) + $urandom_range(8);
      end
      run_ticks(len, low_pct);
      sent = sent + len + 1;
    end

    drain();
    repeat (8) @(negedge clk);
    $display("tb: %0d results compared over %0d reads, %0d bytes received",
             checked, starts, bytes_seen);
    $display("tb: %0d reads ended with a stop, %0d on a missing acknowledge",
             done_ok, ack_errs);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
